[rtl/cfbr_pkg.sv]
// ============================================================================
// cfbr_pkg: shared definitions for the continued-fraction ratio block
// Holds widths, parameter defaults and the sequencer state type.
// ============================================================================
package cfbr_pkg;

    localparam int RATIO_W       = 64;
    localparam int TERM_LIMIT_W  = 32;
    localparam int NUM_W         = 32;
    localparam int STEPS_W       = 6;

    localparam int MAX_STEPS_DEF = 32;
    localparam int FRAC_BITS_DEF = 32;
    localparam int TERM_BITS_DEF = 32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_MAC_DEN,
        ST_MAC_NUM,
        ST_MAC_WAIT,
        ST_UPDATE,
        ST_DONE
    } state_t;

endpackage

[rtl/cfbr_div.sv]
// ============================================================================
// cfbr_div: bit-serial restoring divider
// Produces one quotient bit per cycle; quotient and remainder hold after done.
// ============================================================================
module cfbr_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [cfbr_pkg::RATIO_W-1:0] dividend,
    input  logic [cfbr_pkg::RATIO_W-1:0] divisor,
    output logic                         done,
    output logic                         busy,
    output logic [cfbr_pkg::RATIO_W-1:0] quotient,
    output logic [cfbr_pkg::RATIO_W-1:0] remainder
);

    localparam int W     = cfbr_pkg::RATIO_W;
    localparam int CNT_W = $clog2(W);

    logic [W-1:0]     rem_reg;
    logic [W-1:0]     quo_reg;
    logic [W-1:0]     dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             active_reg;
    logic             done_reg;

    logic [W:0]       trial;
    logic [W:0]       diff;
    logic             fits;
    logic [W-1:0]     rem_next;
    logic [W-1:0]     quo_next;

    always_comb begin
        trial    = {rem_reg, quo_reg[W-1]};
        diff     = trial - {1'b0, dvs_reg};
        fits     = ~diff[W];
        rem_next = fits ? diff[W-1:0] : trial[W-1:0];
        quo_next = {quo_reg[W-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                active_reg <= 1'b1;
                cnt_reg    <= '0;
            end else if (active_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(W - 1)) begin
                    active_reg <= 1'b0;
                    done_reg   <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end else if (active_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done      = done_reg;
    assign busy      = active_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

[rtl/cfbr_mac.sv]
// ============================================================================
// cfbr_mac: two-stage multiply-add with limit check
// Computes term * cur + prev and flags whether the result stays within limit.
// ============================================================================
module cfbr_mac #(
    parameter int TERM_BITS = cfbr_pkg::TERM_BITS_DEF
) (
    input  logic                         aclk,
    input  logic [cfbr_pkg::RATIO_W-1:0] term,
    input  logic [TERM_BITS-1:0]         cur,
    input  logic [TERM_BITS-1:0]         prev,
    input  logic [TERM_BITS-1:0]         lim,
    output logic [TERM_BITS-1:0]         value,
    output logic                         ok
);

    localparam int PW = 2 * TERM_BITS;

    logic [PW-1:0]        prod_reg;
    logic [TERM_BITS-1:0] prev_reg;
    logic                 over_reg;
    logic                 cur_zero_reg;
    logic [TERM_BITS-1:0] value_reg;
    logic                 ok_reg;

    logic [PW:0]          sum;

    always_ff @(posedge aclk) begin
        prod_reg     <= PW'(TERM_BITS'(term)) * PW'(cur);
        prev_reg     <= prev;
        over_reg     <= term > cfbr_pkg::RATIO_W'(lim);
        cur_zero_reg <= (cur == '0);
    end

    assign sum = {1'b0, prod_reg} + (PW + 1)'(prev_reg);

    always_ff @(posedge aclk) begin
        if (cur_zero_reg) begin
            value_reg <= prev_reg;
            ok_reg    <= (prev_reg <= lim);
        end else begin
            value_reg <= sum[TERM_BITS-1:0];
            ok_reg    <= !over_reg && (sum <= (PW + 1)'(lim));
        end
    end

    assign value = value_reg;
    assign ok    = ok_reg;

endmodule

[rtl/continued_fraction_best_ratio.sv]
// ============================================================================
// continued_fraction_best_ratio: best rational approximation of a ratio
// Expands the magnitude of a signed fixed-point ratio as a continued fraction
// and returns the last convergent whose terms stay within the term limit.
//
//   Channel   Direction  Ports
//   s_        in         s_valid, s_ready, s_ratio_value
//   m_        out        m_valid, m_ready, m_numerator, m_denominator,
//                        m_steps_taken, m_exact
//   cfg_      in         cfg_valid, cfg_ready, cfg_data (term limit)
//
// Each convergent step runs the bit-serial divider and then the shared
// multiply-add, which is used once for the denominator and once for the
// numerator. A request takes up to MAX_STEPS + 2 steps. Reset clears the
// sequencer, the output valid and the term limit. A new request is taken
// while a result waits; a second result then holds until the first
// is taken.
// ============================================================================
module continued_fraction_best_ratio #(
    parameter int MAX_STEPS = cfbr_pkg::MAX_STEPS_DEF,
    parameter int FRAC_BITS = cfbr_pkg::FRAC_BITS_DEF,
    parameter int TERM_BITS = cfbr_pkg::TERM_BITS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [cfbr_pkg::TERM_LIMIT_W-1:0]      cfg_data,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [cfbr_pkg::RATIO_W-1:0]    s_ratio_value,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [cfbr_pkg::NUM_W-1:0]             m_numerator,
    output logic [cfbr_pkg::NUM_W-1:0]             m_denominator,
    output logic [cfbr_pkg::STEPS_W-1:0]           m_steps_taken,
    output logic                                   m_exact
);

    localparam int RW    = cfbr_pkg::RATIO_W;
    localparam int CNT_W = $clog2(MAX_STEPS + 3);
    localparam logic [TERM_BITS-1:0] TERM_TOP = '1;

    cfbr_pkg::state_t state_reg;
    cfbr_pkg::state_t state_next;

    logic [cfbr_pkg::TERM_LIMIT_W-1:0] term_limit_reg;
    logic [TERM_BITS-1:0]              lim;

    logic [RW-1:0]        rn_reg;
    logic [RW-1:0]        rd_reg;
    logic [TERM_BITS-1:0] np_reg;
    logic [TERM_BITS-1:0] nc_reg;
    logic [TERM_BITS-1:0] dp_reg;
    logic [TERM_BITS-1:0] dc_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [TERM_BITS-1:0] nd_reg;
    logic                 nd_ok_reg;

    logic                          m_valid_reg;
    logic [cfbr_pkg::NUM_W-1:0]    m_numerator_reg;
    logic [cfbr_pkg::NUM_W-1:0]    m_denominator_reg;
    logic [cfbr_pkg::STEPS_W-1:0]  m_steps_taken_reg;
    logic                          m_exact_reg;

    logic [RW-1:0]        mag;
    logic                 in_accept;
    logic                 more_steps;
    logic                 div_start;
    logic                 div_done;
    logic                 div_busy;
    logic [RW-1:0]        div_quo;
    logic [RW-1:0]        div_rem;
    logic                 mac_sel_num;
    logic [TERM_BITS-1:0] mac_cur;
    logic [TERM_BITS-1:0] mac_prev;
    logic [TERM_BITS-1:0] mac_v;
    logic                 mac_ok;
    logic                 step_ok;
    logic                 out_load;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            term_limit_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            term_limit_reg <= cfg_data;
        end
    end

    always_comb begin
        if (term_limit_reg == '0 || term_limit_reg > cfbr_pkg::TERM_LIMIT_W'(TERM_TOP)) begin
            lim = TERM_TOP;
        end else begin
            lim = TERM_BITS'(term_limit_reg);
        end
    end

    assign mag        = s_ratio_value[RW-1] ? (~$unsigned(s_ratio_value) + 1'b1)
                                            : $unsigned(s_ratio_value);
    assign in_accept  = s_valid && s_ready;
    assign more_steps = (rn_reg != '0) && (cnt_reg != CNT_W'(MAX_STEPS + 2));
    assign step_ok    = nd_ok_reg && mac_ok;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            cfbr_pkg::ST_IDLE: begin
                if (in_accept) begin
                    state_next = cfbr_pkg::ST_CHECK;
                end
            end
            cfbr_pkg::ST_CHECK: begin
                state_next = more_steps ? cfbr_pkg::ST_DIV : cfbr_pkg::ST_DONE;
            end
            cfbr_pkg::ST_DIV: begin
                if (div_done) begin
                    state_next = cfbr_pkg::ST_MAC_DEN;
                end
            end
            cfbr_pkg::ST_MAC_DEN:  state_next = cfbr_pkg::ST_MAC_NUM;
            cfbr_pkg::ST_MAC_NUM:  state_next = cfbr_pkg::ST_MAC_WAIT;
            cfbr_pkg::ST_MAC_WAIT: state_next = cfbr_pkg::ST_UPDATE;
            cfbr_pkg::ST_UPDATE: begin
                state_next = step_ok ? cfbr_pkg::ST_CHECK : cfbr_pkg::ST_DONE;
            end
            cfbr_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = cfbr_pkg::ST_IDLE;
                end
            end
            default: state_next = cfbr_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready     = 1'b0;
        div_start   = 1'b0;
        mac_sel_num = 1'b0;
        out_load    = 1'b0;
        case (state_reg)
            cfbr_pkg::ST_IDLE:    s_ready     = 1'b1;
            cfbr_pkg::ST_CHECK:   div_start   = more_steps;
            cfbr_pkg::ST_MAC_NUM: mac_sel_num = 1'b1;
            cfbr_pkg::ST_DONE:    out_load    = !m_valid_reg || m_ready;
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cfbr_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    cfbr_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (rd_reg),
        .divisor   (rn_reg),
        .done      (div_done),
        .busy      (div_busy),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign mac_cur  = mac_sel_num ? nc_reg : dc_reg;
    assign mac_prev = mac_sel_num ? np_reg : dp_reg;

    cfbr_mac #(
        .TERM_BITS (TERM_BITS)
    ) u_mac (
        .aclk  (aclk),
        .term  (div_quo),
        .cur   (mac_cur),
        .prev  (mac_prev),
        .lim   (lim),
        .value (mac_v),
        .ok    (mac_ok)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (in_accept) begin
            cnt_reg <= '0;
        end else if (state_reg == cfbr_pkg::ST_UPDATE && step_ok) begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            rn_reg <= mag;
            rd_reg <= RW'(1) << FRAC_BITS;
            np_reg <= TERM_BITS'(1);
            nc_reg <= '0;
            dp_reg <= '0;
            dc_reg <= TERM_BITS'(1);
        end else if (state_reg == cfbr_pkg::ST_UPDATE && step_ok) begin
            dp_reg <= dc_reg;
            dc_reg <= nd_reg;
            np_reg <= nc_reg;
            nc_reg <= mac_v;
            rd_reg <= rn_reg;
            rn_reg <= div_rem;
        end
        if (state_reg == cfbr_pkg::ST_MAC_WAIT) begin
            nd_reg    <= mac_v;
            nd_ok_reg <= mac_ok;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_numerator_reg   <= cfbr_pkg::NUM_W'(nc_reg);
            m_denominator_reg <= cfbr_pkg::NUM_W'(dc_reg);
            m_steps_taken_reg <= cfbr_pkg::STEPS_W'(cnt_reg);
            m_exact_reg       <= (rn_reg == '0);
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_numerator   = m_numerator_reg;
    assign m_denominator = m_denominator_reg;
    assign m_steps_taken = m_steps_taken_reg;
    assign m_exact       = m_exact_reg;

    a_div_start_idle : assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_busy)
        else $error("Divider started while still running.");

    a_accept_to_check : assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> (state_reg == cfbr_pkg::ST_CHECK))
        else $error("Accepted request did not start the expansion.");

    a_step_within_limit : assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == cfbr_pkg::ST_UPDATE && step_ok) |-> (mac_v <= lim && nd_reg <= lim))
        else $error("Accepted convergent exceeds the term limit.");

    a_step_count_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_STEPS + 2))
        else $error("Step count ran past the step bound.");

endmodule
